// File: rtl/stim_pkg.sv
// Shared types, constants and text tables of the stream title metadata inserter.
`default_nettype none

package stim_pkg;

   // Input item kinds.
   localparam logic [1:0] MODE_AUDIO  = 2'd0;
   localparam logic [1:0] MODE_APPEND = 2'd1;
   localparam logic [1:0] MODE_COMMIT = 2'd2;

   // Title store geometry: two banks of 32 bytes.
   localparam int BANK_SIZE   = 32;
   localparam int TITLE_AW    = 6;
   localparam int LEN_W       = 5;
   localparam int CMDQ_DEPTH  = 2;

   // Block layout.
   localparam logic [5:0] PREFIX_LEN = 6'd13;
   localparam logic [5:0] LEN_BIAS   = 6'd32;
   localparam logic [7:0] CHAR_QUOTE = 8'h27;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;

   // One audio transaction as handed from the front to the back.
   typedef struct packed {
      logic [7:0]       audio;
      logic             ins;
      logic             full_blk;
      logic             bank;
      logic [LEN_W-1:0] tlen;
   } stim_cmd_type;

   // Characters of the fixed text that opens a title block.
   function automatic logic [7:0] prefix_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = 8'h53; // S
         4'd1:    ch = 8'h74; // t
         4'd2:    ch = 8'h72; // r
         4'd3:    ch = 8'h65; // e
         4'd4:    ch = 8'h61; // a
         4'd5:    ch = 8'h6D; // m
         4'd6:    ch = 8'h54; // T
         4'd7:    ch = 8'h69; // i
         4'd8:    ch = 8'h74; // t
         4'd9:    ch = 8'h6C; // l
         4'd10:   ch = 8'h65; // e
         4'd11:   ch = 8'h3D; // =
         4'd12:   ch = 8'h27; // quote
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

// File: rtl/stim_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module stim_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/stim_front.sv
// Front end: accepts transactions, stages titles, counts audio and issues commands.
`default_nettype none

module stim_front #(
   parameter int TITLE_MAX = 31
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [15:0]                    csr_wr_data,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic [1:0]                     req_mode,
   input  wire logic [7:0]                     req_data_byte,
   output logic                                ram_wr_en,
   output logic [stim_pkg::TITLE_AW-1:0]       ram_wr_addr,
   output logic [7:0]                          ram_wr_data,
   output logic                                cmd_push,
   output stim_pkg::stim_cmd_type              cmd_data,
   input  wire logic                           cmd_full,
   input  wire logic                           blk_done
);
   import stim_pkg::*;

   logic [15:0]      interval_ff, interval_in;
   logic [15:0]      count_ff, count_in;
   logic             bank_ff, bank_in;
   logic [LEN_W-1:0] staged_ff, staged_in;
   logic [LEN_W-1:0] committed_ff, committed_in;
   logic             pending_ff, pending_in;
   logic             busy_ff, busy_in;

   logic             accept;
   logic [16:0]      count_next;
   logic             insert;

   // While a title block is in flight its bank must not be rewritten.
   assign req_full = cmd_full | busy_ff;
   assign accept   = req_push & ~req_full;

   assign count_next = {1'b0, count_ff} + 17'd1;
   assign insert     = (interval_ff != 16'd0) && (count_next >= {1'b0, interval_ff});

   always_comb begin
      interval_in  = csr_wr_en ? csr_wr_data : interval_ff;
      count_in     = count_ff;
      bank_in      = bank_ff;
      staged_in    = staged_ff;
      committed_in = committed_ff;
      pending_in   = pending_ff;
      busy_in      = busy_ff & ~blk_done;
      ram_wr_en    = 1'b0;
      cmd_push     = 1'b0;
      cmd_data.audio    = req_data_byte;
      cmd_data.ins      = insert;
      cmd_data.full_blk = pending_ff;
      cmd_data.bank     = bank_ff;
      cmd_data.tlen     = committed_ff;
      if (accept) begin
         case (req_mode)
            MODE_AUDIO: begin
               cmd_push = 1'b1;
               if (interval_ff != 16'd0) begin
                  count_in = insert ? 16'd0 : count_next[15:0];
               end
               if (insert) begin
                  pending_in = 1'b0;
                  busy_in    = pending_ff;
               end
            end
            MODE_APPEND: begin
               if (staged_ff < LEN_W'(TITLE_MAX)) begin
                  ram_wr_en = 1'b1;
                  staged_in = staged_ff + LEN_W'(1);
               end
            end
            MODE_COMMIT: begin
               bank_in      = ~bank_ff;
               committed_in = staged_ff;
               staged_in    = '0;
               pending_in   = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   assign ram_wr_addr = {~bank_ff, staged_ff};
   assign ram_wr_data = req_data_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= 16'd16000;
         count_ff     <= '0;
         bank_ff      <= 1'b0;
         staged_ff    <= '0;
         committed_ff <= '0;
         pending_ff   <= 1'b0;
         busy_ff      <= 1'b0;
      end else begin
         interval_ff  <= interval_in;
         count_ff     <= count_in;
         bank_ff      <= bank_in;
         staged_ff    <= staged_in;
         committed_ff <= committed_in;
         pending_ff   <= pending_in;
         busy_ff      <= busy_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/stim_cmdq.sv
// Two-entry command queue between the front end and the back end.
`default_nettype none

module stim_cmdq (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  stim_pkg::stim_cmd_type push_data,
   output logic                  full,
   input  wire logic             pop,
   output stim_pkg::stim_cmd_type pop_data,
   output logic                  empty
);
   import stim_pkg::*;

   localparam int PW = $clog2(CMDQ_DEPTH);

   stim_cmd_type   entry_ff [CMDQ_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PW:0]    cnt_ff, cnt_in;

   assign full     = (cnt_ff == (PW+1)'(CMDQ_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/stim_back.sv
// Back end: sequences audio and metadata bytes into the result register.
`default_nettype none

module stim_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  stim_pkg::stim_cmd_type         cmd_data,
   input  wire logic                      cmd_empty,
   output logic                           cmd_pop,
   output logic                           ram_rd_en,
   output logic [stim_pkg::TITLE_AW-1:0]  ram_rd_addr,
   input  wire logic [7:0]                ram_rd_data,
   output logic                           blk_done,
   output logic                           rsp_empty,
   input  wire logic                      rsp_pop,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_is_metadata,
   output logic                           rsp_last_of_run
);
   import stim_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_INS, ST_BODY} state_type;

   typedef struct packed {
      logic [7:0] data;
      logic       from_ram;
      logic       meta;
      logic       last;
   } desc_type;

   state_type        state_ff;
   stim_cmd_type     cmd_ff;
   logic [5:0]       pos_ff;
   logic [1:0]       len_ff;
   logic             out_valid_ff;
   desc_type         out_ff;

   desc_type         desc;
   logic             desc_valid;
   logic             advance;
   logic [1:0]       len_calc;
   logic [5:0]       tend;
   logic [5:0]       tidx;
   logic [5:0]       pos_last;

   assign advance  = ~out_valid_ff | rsp_pop;
   assign len_calc = 2'((6'(cmd_ff.tlen) + LEN_BIAS) >> 4);
   assign tend     = PREFIX_LEN + 6'(cmd_ff.tlen);
   assign tidx     = pos_ff - PREFIX_LEN;
   // The body is 16 bytes per length unit, so its last position is 16 * len - 1.
   assign pos_last = {len_ff - 2'd1, 4'hF};

   always_comb begin
      desc       = '{data: 8'h00, from_ram: 1'b0, meta: 1'b1, last: 1'b0};
      desc_valid = 1'b0;
      cmd_pop    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            desc_valid = ~cmd_empty;
            cmd_pop    = ~cmd_empty & advance;
            desc.data  = cmd_data.audio;
            desc.meta  = 1'b0;
            desc.last  = ~cmd_data.ins;
         end
         ST_INS: begin
            desc_valid = 1'b1;
            desc.data  = cmd_ff.full_blk ? {6'd0, len_calc} : 8'h00;
            desc.last  = ~cmd_ff.full_blk;
         end
         ST_BODY: begin
            desc_valid = 1'b1;
            desc.last  = (pos_ff == pos_last);
            if (pos_ff < PREFIX_LEN) begin
               desc.data = prefix_char(pos_ff[3:0]);
            end else if (pos_ff < tend) begin
               desc.from_ram = 1'b1;
            end else if (pos_ff == tend) begin
               desc.data = CHAR_QUOTE;
            end else if (pos_ff == tend + 6'd1) begin
               desc.data = CHAR_SEMI;
            end
         end
         default: begin
         end
      endcase
   end

   assign ram_rd_en   = advance & desc_valid & desc.from_ram;
   assign ram_rd_addr = {cmd_ff.bank, tidx[LEN_W-1:0]};
   assign blk_done    = advance & (state_ff == ST_BODY) & desc.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= desc_valid;
         out_ff       <= desc;
         case (state_ff)
            ST_IDLE: begin
               if (~cmd_empty) begin
                  cmd_ff <= cmd_data;
                  if (cmd_data.ins) begin
                     state_ff <= ST_INS;
                  end
               end
            end
            ST_INS: begin
               pos_ff <= '0;
               len_ff <= len_calc;
               state_ff <= cmd_ff.full_blk ? ST_BODY : ST_IDLE;
            end
            ST_BODY: begin
               pos_ff <= pos_ff + 6'd1;
               if (desc.last) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_empty       = ~out_valid_ff;
   assign rsp_out_byte    = out_ff.from_ram ? ram_rd_data : out_ff.data;
   assign rsp_is_metadata = out_ff.meta;
   assign rsp_last_of_run = out_ff.last;

endmodule

`default_nettype wire

// File: rtl/stream_title_metadata_inserter.sv
// Top level of the stream title metadata inserter.
`default_nettype none

// Channel   Ports                                            Direction
// req       req_push, req_full, req_mode, req_data_byte      in (queue write side)
// rsp       rsp_empty, rsp_pop, rsp_out_byte,
//           rsp_is_metadata, rsp_last_of_run                 out (queue read side)
// csr       csr_wr_en, csr_wr_data (meta_interval)           in (write only)
//
// The back-end sequencer emits the output bytes in order, so an audio
// transaction yields one byte, or up to 50 bytes when it triggers a title block.
// Title and commit transactions produce no output.
// Reset is synchronous; the title store is not cleared and needs no sweep.
// req_full rises when the two-entry command queue is full and also for as long as
// a title block is being sequenced, which keeps its bank from being overwritten.
// The result register frees the back end from a stalled consumer for one byte.

module stream_title_metadata_inserter #(
   parameter int TITLE_MAX = 31
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_mode,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_is_metadata,
   output logic             rsp_last_of_run
);
   import stim_pkg::*;

   logic                ram_wr_en;
   logic [TITLE_AW-1:0] ram_wr_addr;
   logic [7:0]          ram_wr_data;
   logic                ram_rd_en;
   logic [TITLE_AW-1:0] ram_rd_addr;
   logic [7:0]          ram_rd_data;

   logic                cmd_push;
   logic                cmd_pop;
   logic                cmd_full;
   logic                cmd_empty;
   stim_cmd_type        cmd_in;
   stim_cmd_type        cmd_out;
   logic                blk_done;

   // The front end owns the counter, the bank pointer and the pending flag, so
   // every command leaves it with a consistent snapshot of the title state.
   stim_front #(
      .TITLE_MAX (TITLE_MAX)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_mode      (req_mode),
      .req_data_byte (req_data_byte),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .cmd_push      (cmd_push),
      .cmd_data      (cmd_in),
      .cmd_full      (cmd_full),
      .blk_done      (blk_done)
   );

   stim_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .empty     (cmd_empty)
   );

   // Both title banks live in one RAM; the bank is the address MSB.
   stim_ram #(
      .WIDTH (8),
      .DEPTH (2 * BANK_SIZE)
   ) u_title_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   stim_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_data        (cmd_out),
      .cmd_empty       (cmd_empty),
      .cmd_pop         (cmd_pop),
      .ram_rd_en       (ram_rd_en),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .blk_done        (blk_done),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_is_metadata (rsp_is_metadata),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the stream title metadata inserter.
`timescale 1ns / 100ps

module tb_top;
   import stim_pkg::*;

   // The block ignores this mode, so it must produce no output bytes.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam int          TITLE_MAX     = 31;
   localparam logic [7:0]  QUOTE_CHAR    = 8'h27;
   localparam logic [7:0]  SEMI_CHAR     = 8'h3B;
   localparam logic [8*13-1:0] TITLE_TAG = "StreamTitle='";

   // Cycles allowed after the last output byte before the block counts as idle.
   // A title block is at most 49 bytes, one per cycle while the receiver pops, plus the command queue.
   localparam int SETTLE_CYCLES = 64;
   // Cycles with no transaction on either side before the run is declared hung.
   // The longest intended quiet stretch is the receiver hold-off below.
   localparam int QUIET_LIMIT   = 3000;
   localparam int HOLD_OFF      = 300;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_metadata;
      logic       last_of_run;
   } stream_byte_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'd0;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [1:0]  req_mode = MODE_AUDIO;
   logic [7:0]  req_data_byte = 8'd0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_is_metadata;
   logic        rsp_last_of_run;

   // Mirror of the inserter state, advanced once per accepted transaction.
   logic [15:0] p_interval = 16'd16000;
   logic [15:0] p_audio_count = 16'd0;
   logic [7:0]  p_banks [64];
   logic        p_front_bank = 1'b0;
   logic [4:0]  p_staged_len = 5'd0;
   logic [4:0]  p_committed_len = 5'd0;
   logic        p_block_due = 1'b0;

   // Output bytes the stream still owes, oldest first.
   stream_byte_t stream_bytes_q[$];

   int fault_count = 0;
   int quiet_cycles = 0;
   int rx_hold_cycles = 0;
   bit tx_idle_on = 1'b1;
   bit rx_idle_on = 1'b1;

   stream_title_metadata_inserter #(.TITLE_MAX(TITLE_MAX)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_mode        (req_mode),
      .req_data_byte   (req_data_byte),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_is_metadata (rsp_is_metadata),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void push_stream_byte(input logic [7:0] b, input logic meta,
                                            input logic last);
      stream_byte_t entry;
      entry.out_byte    = b;
      entry.is_metadata = meta;
      entry.last_of_run = last;
      stream_bytes_q.push_back(entry);
   endfunction

   // Advances the mirrored state by one transaction and queues the bytes it
   // puts on the output stream.
   function automatic void advance_inserter(input logic [1:0] mode, input logic [7:0] data);
      int         next_count;
      int         tlen;
      int         padded;
      int         pos;
      logic [7:0] b;
      logic       fires;
      case (mode)
         MODE_APPEND: begin
            // Characters past the title limit are dropped silently.
            if (p_staged_len < TITLE_MAX) begin
               p_banks[{~p_front_bank, p_staged_len}] = data;
               p_staged_len = p_staged_len + 5'd1;
            end
         end
         MODE_COMMIT: begin
            // A commit while a block is still due simply replaces the title.
            p_front_bank    = ~p_front_bank;
            p_committed_len = p_staged_len;
            p_staged_len    = 5'd0;
            p_block_due     = 1'b1;
         end
         MODE_AUDIO: begin
            next_count = int'(p_audio_count) + 1;
            fires = (p_interval != 16'd0) && (next_count >= int'(p_interval));
            push_stream_byte(data, 1'b0, !fires);
            // With the interval at zero the count is held where it is.
            if (p_interval != 16'd0)
               p_audio_count = fires ? 16'd0 : 16'(next_count);
            if (fires && !p_block_due) begin
               push_stream_byte(8'd0, 1'b1, 1'b1);
            end else if (fires) begin
               tlen   = int'(p_committed_len);
               padded = ((tlen + 17 + 15) / 16) * 16;
               push_stream_byte(8'(padded / 16), 1'b1, 1'b0);
               // Body: tag, title, closing quote and semicolon, zero padding.
               for (int k = 1; k <= padded; k++) begin
                  pos = k - 1;
                  if (pos < 13)
                     b = TITLE_TAG[8*(12-pos) +: 8];
                  else if (pos < 13 + tlen)
                     b = p_banks[{p_front_bank, 5'(pos - 13)}];
                  else if (pos == 13 + tlen)
                     b = QUOTE_CHAR;
                  else if (pos == 14 + tlen)
                     b = SEMI_CHAR;
                  else
                     b = 8'd0;
                  push_stream_byte(b, 1'b1, k == padded);
               end
               p_block_due = 1'b0;
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void check_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         fault_count++;
      end
   endfunction

   // Offers one transaction after a random gap and holds it until the block
   // takes it. Called only at a rising edge; the mirror advances on acceptance.
   task automatic send_item(input logic [1:0] mode, input logic [7:0] data);
      int gap;
      gap = tx_idle_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_mode      <= mode;
      req_data_byte <= data;
      @(posedge clock);
      while (req_full) @(posedge clock);
      advance_inserter(mode, data);
   endtask

   // Stops offering, waits for every owed byte, then lets the block finish any
   // title or commit transaction that produced nothing.
   task automatic settle_idle();
      req_push <= 1'b0;
      while (stream_bytes_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Only called once the block is idle.
   task automatic write_meta_interval(input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      p_interval = value;
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_default_interval();
      // The reset interval is far away, so audio passes straight through.
      send_item(MODE_AUDIO, 8'h00);
      send_item(MODE_AUDIO, 8'hFF);
      settle_idle();
   endtask

   task automatic test_zero_interval();
      // Interval zero disables insertion and freezes the audio count.
      write_meta_interval(16'd0);
      send_item(MODE_AUDIO, 8'hA5);
      send_item(MODE_AUDIO, 8'h5A);
      settle_idle();
   endtask

   task automatic test_bare_marker();
      // The count already exceeds the new interval; with no title due the
      // insertion is a single zero byte.
      write_meta_interval(16'd1);
      send_item(MODE_AUDIO, 8'h5A);
      settle_idle();
   endtask

   task automatic test_title_block();
      // Zero and all-ones characters travel like any other title character.
      send_item(MODE_APPEND, 8'h00);
      send_item(MODE_APPEND, 8'hFF);
      send_item(MODE_APPEND, 8'h41);
      send_item(MODE_COMMIT, 8'hFF);
      send_item(MODE_AUDIO, 8'h3C);
      // An empty commit still produces a block with an empty title.
      send_item(MODE_COMMIT, 8'h00);
      send_item(MODE_AUDIO, 8'hC3);
      settle_idle();
   endtask

   task automatic test_replaced_title();
      // Two commits before an insertion: only the second title is sent.
      write_meta_interval(16'd3);
      send_item(MODE_APPEND, 8'h61);
      send_item(MODE_COMMIT, 8'h00);
      send_item(MODE_APPEND, 8'h62);
      send_item(MODE_APPEND, 8'h63);
      send_item(MODE_COMMIT, 8'h00);
      repeat (3) send_item(MODE_AUDIO, 8'($urandom));
      // The unused mode must be swallowed without output.
      send_item(MODE_UNUSED, 8'hFF);
      settle_idle();
   endtask

   task automatic test_lowered_interval();
      // Build up a count under the widest interval, then cut the interval
      // below it: the next audio transaction triggers the block at once.
      write_meta_interval(16'hFFFF);
      repeat (4) send_item(MODE_AUDIO, 8'($urandom));
      send_item(MODE_COMMIT, 8'h00);
      settle_idle();
      write_meta_interval(16'd2);
      send_item(MODE_AUDIO, 8'h81);
      settle_idle();
   endtask

   task automatic test_title_overflow();
      // More characters than the title holds; the longest block results.
      write_meta_interval(16'd4);
      repeat (34) send_item(MODE_APPEND, 8'($urandom));
      send_item(MODE_COMMIT, 8'($urandom));
      repeat (4) send_item(MODE_AUDIO, 8'($urandom));
      settle_idle();
   endtask

   task automatic test_backpressure();
      // The receiver stops for a long stretch while audio keeps coming, so the
      // block fills and must hold req_full until the receiver resumes.
      write_meta_interval(16'd1);
      tx_idle_on = 1'b0;
      repeat (4) send_item(MODE_APPEND, 8'($urandom));
      send_item(MODE_COMMIT, 8'($urandom));
      rx_hold_cycles = HOLD_OFF;
      repeat (20) send_item(MODE_AUDIO, 8'($urandom));
      tx_idle_on = 1'b1;
      settle_idle();
   endtask

   // Mostly well-formed title updates and audio, with stray appends, lone
   // commits and ignored transactions mixed in.
   task automatic random_stream(input int budget);
      int sent;
      int pick;
      int tlen;
      sent = 0;
      while (sent < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            send_item(MODE_AUDIO, 8'($urandom));
            sent++;
         end else if (pick < 80) begin
            tlen = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36)
                                                : $urandom_range(0, 6);
            repeat (tlen) send_item(MODE_APPEND, 8'($urandom));
            send_item(MODE_COMMIT, 8'($urandom));
            sent += tlen + 1;
         end else if (pick < 92) begin
            send_item(MODE_APPEND, 8'($urandom));
            sent++;
         end else if (pick < 97) begin
            send_item(MODE_COMMIT, 8'($urandom));
            sent++;
         end else begin
            send_item(MODE_UNUSED, 8'($urandom));
         end
      end
   endtask

   task automatic run_random_phase(input logic [15:0] interval, input bit tx_idle,
                                   input bit rx_idle, input int budget);
      write_meta_interval(interval);
      tx_idle_on = tx_idle;
      rx_idle_on = rx_idle;
      random_stream(budget);
      settle_idle();
   endtask

   task automatic test_random_traffic();
      run_random_phase(16'd1, 1'b1, 1'b1, 50);
      run_random_phase(16'($urandom_range(2, 6)), 1'b1, 1'b0, 50);
      run_random_phase(16'($urandom_range(7, 30)), 1'b0, 1'b1, 50);
      run_random_phase(16'd0, 1'b1, 1'b1, 15);
      run_random_phase(16'd2, 1'b0, 1'b0, 40);
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   // Receiver: pops after a random stall and checks each output byte against
   // the oldest one owed. A requested hold-off is counted here in cycles.
   initial begin : stream_sink
      int           stall;
      int           hold;
      stream_byte_t want;
      while (reset) @(posedge clock);
      forever begin
         if (rx_hold_cycles > 0) begin
            hold = rx_hold_cycles;
            rx_hold_cycles = 0;
            rsp_pop <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         stall = rx_idle_on ? $urandom_range(0, 12) : 0;
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         if (stream_bytes_q.size() == 0) begin
            $error("output byte 0x%0h arrived with nothing owed", rsp_out_byte);
            fault_count++;
         end else begin
            want = stream_bytes_q.pop_front();
            check_field("out_byte", want.out_byte, rsp_out_byte);
            check_field("is_metadata", want.is_metadata, rsp_is_metadata);
            check_field("last_of_run", want.last_of_run, rsp_last_of_run);
         end
      end
   end

   // Watchdog: a hung handshake shows up as a long run of quiet cycles.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** stream_title_metadata_inserter: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_default_interval();
      test_zero_interval();
      test_bare_marker();
      test_title_block();
      test_replaced_title();
      test_lowered_interval();
      test_title_overflow();
      test_backpressure();
      test_random_traffic();
      // settle_idle has already drained the stream and waited out the latency.
      settle_idle();
      if (fault_count == 0)
         $display("** stream_title_metadata_inserter: PASSED **");
      else
         $display("** stream_title_metadata_inserter: FAILED **");
      $finish;
   end

endmodule
